@@ sv/ndr3_pkg.sv @@
`default_nettype none
package ndr3_pkg;
  localparam int unsigned PIX_W = 16;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned COL_W = 12;
  localparam int unsigned SUM_W = 36;
  localparam int unsigned ROOT_W = 18;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_ADD     = 2'd2;
  localparam logic [1:0] CFG_COMPUTE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch input, read line stores
    logic load;      // start sums
    logic acc;       // add one squared difference
    logic sqrt_start;
    logic sqrt_step;
    logic finish;    // commit state, form results
    logic pop;       // drop head result
  } ndr3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sqrt;
    logic sqrt_done;
    logic acc_done;
    logic res_empty;
  } ndr3_sts_t;
endpackage
`default_nettype wire

@@ sv/ndr3_datapath.sv @@
`default_nettype none
module ndr3_datapath #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ndr3_pkg::ndr3_cmd_t   cmd_i,
  output ndr3_pkg::ndr3_sts_t        sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i,
  input  wire logic [15:0]           pixel_value_i,
  input  wire logic [7:0]            mask_value_i,
  output logic                       write_enable_o,
  output logic [15:0]                out_row_o,
  output logic [11:0]                out_column_o,
  output logic [15:0]                out_value_o,
  output logic                       last_of_run_o
);
  import ndr3_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic        add_q, comp_q;
  logic [WW-1:0] effw;
  logic [15:0] effh;
  always_comb begin
    if (width_q < 13'd3) effw = WW'(3);
    else if ({19'd0, width_q} > 32'(MAX_WIDTH)) effw = WW'(MAX_WIDTH);
    else effw = WW'(width_q);
    effh = (height_q < 16'd3) ? 16'd3 : height_q;
  end

  // position
  logic [AW-1:0] col_q;
  logic [15:0]   row_q;

  // line stores
  logic [15:0] upper_mem [MAX_WIDTH];
  logic [16:0] middle_mem [MAX_WIDTH];
  logic [15:0] up_q;
  logic [16:0] mv_q;
  logic [15:0] pix_q;
  logic [7:0]  msk_q;
  logic [AW-1:0] c_q;
  logic [15:0] r_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      up_q <= upper_mem[col_q];
      mv_q <= middle_mem[col_q];
    end
    if (cmd_i.finish) begin
      upper_mem[c_q]  <= mv_q[15:0];
      middle_mem[c_q] <= {(msk_q == 8'hFF), pix_q};
    end
  end

  // window
  logic [15:0] a_top_q, a_mid_q, a_bot_q, b_top_q, b_mid_q, b_bot_q;
  logic        b_flag_q;

  // accumulation over eight neighbors
  logic [15:0] nb [8];
  assign nb[0] = a_top_q; assign nb[1] = a_mid_q; assign nb[2] = a_bot_q;
  assign nb[3] = b_top_q; assign nb[4] = b_bot_q; assign nb[5] = up_q;
  assign nb[6] = mv_q[15:0]; assign nb[7] = pix_q;
  logic [3:0]  k_q;
  logic [35:0] sum_q;
  logic [15:0] dif;
  logic [31:0] sq_q;
  logic        sqv_q;
  assign dif = (b_mid_q >= nb[k_q[2:0]]) ? b_mid_q - nb[k_q[2:0]]
                                         : nb[k_q[2:0]] - b_mid_q;

  // interior / border decisions
  logic interior, border;
  assign interior = (r_q >= 16'd2) && ({{(32-AW){1'b0}}, c_q} >= 32'd2);
  assign border = (r_q == 16'd0) || (r_q == effh - 16'd1) || (c_q == '0)
                  || ({{(32-AW){1'b0}}, c_q} == 32'(effw) - 32'd1);

  // square root, one result bit per step
  logic [35:0] rem_q;
  logic [17:0] root_q;
  logic [4:0]  sk_q;
  logic [37:0] trial;
  logic [37:0] remsh;
  assign remsh = {rem_q, sum_q[35:34]};
  assign trial = {18'd0, root_q, 2'b01};

  // result queue: two entries
  logic [45:0] q0_q, q1_q;
  logic [1:0]  cnt_q;
  logic [16:0] ival;
  always_comb begin
    ival = {1'b0, b_mid_q};
    if (comp_q) ival = {1'b0, root_q[15:0]} + (add_q ? {1'b0, b_mid_q} : 17'd0);
  end
  logic [15:0] ivs;
  assign ivs = (ival[16] || (comp_q && (root_q[17:16] != 2'd0))) ? 16'hFFFF
                                                                 : ival[15:0];
  logic [45:0] e_int, e_bor;
  logic        bwe;
  assign bwe = msk_q != 8'd0;
  assign e_int = {b_flag_q, r_q - 16'd1, COL_W'(c_q - AW'(1)),
                  b_flag_q ? ivs : 16'd0, !border};
  assign e_bor = {bwe, r_q, COL_W'(c_q), (bwe && add_q) ? pix_q : 16'd0, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd640; height_q <= 16'd480; add_q <= 1'b0; comp_q <= 1'b1;
      col_q <= '0; row_q <= '0; cnt_q <= '0; k_q <= '0; sqv_q <= 1'b0;
      sk_q <= '0;
      a_top_q <= '0; a_mid_q <= '0; a_bot_q <= '0;
      b_top_q <= '0; b_mid_q <= '0; b_bot_q <= '0; b_flag_q <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:   begin width_q <= cfg_data_i[12:0]; col_q <= '0; row_q <= '0; end
          CFG_HEIGHT:  begin height_q <= cfg_data_i; col_q <= '0; row_q <= '0; end
          CFG_ADD:     add_q <= cfg_data_i[0];
          CFG_COMPUTE: comp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // latch item and position
      if (cmd_i.take) begin
        pix_q <= pixel_value_i; msk_q <= mask_value_i;
        c_q <= col_q; r_q <= row_q;
      end
      // start the sum
      if (cmd_i.load) begin
        sum_q <= '0; k_q <= '0; sqv_q <= 1'b0;
      end
      // pipeline: square one diff, add previous
      if (cmd_i.acc) begin
        sq_q <= dif * dif;
        sqv_q <= 1'b1;
        if (sqv_q) sum_q <= sum_q + 36'(sq_q);
        k_q <= k_q + 4'd1;
      end
      if (cmd_i.sqrt_start) begin
        sum_q <= sum_q + 36'(sq_q);
        rem_q <= '0; root_q <= '0; sk_q <= '0;
      end
      if (cmd_i.sqrt_step) begin
        if (remsh >= trial) begin
          rem_q <= 36'(remsh - trial); root_q <= {root_q[16:0], 1'b1};
        end else begin
          rem_q <= remsh[35:0]; root_q <= {root_q[16:0], 1'b0};
        end
        sum_q <= {sum_q[33:0], 2'b00};
        sk_q <= sk_q + 5'd1;
      end
      // commit state, push results, advance position
      if (cmd_i.finish) begin
        a_top_q <= b_top_q; a_mid_q <= b_mid_q; a_bot_q <= b_bot_q;
        b_top_q <= up_q; b_mid_q <= mv_q[15:0]; b_bot_q <= pix_q;
        b_flag_q <= mv_q[16];
        if (interior && border) begin
          q0_q <= e_int; q1_q <= e_bor; cnt_q <= 2'd2;
        end else if (interior) begin
          q0_q <= e_int; cnt_q <= 2'd1;
        end else if (border) begin
          q0_q <= e_bor; cnt_q <= 2'd1;
        end
        if ({{(32-AW){1'b0}}, c_q} + 32'd1 >= 32'(effw)) begin
          col_q <= '0;
          row_q <= (r_q + 16'd1 >= effh) ? 16'd0 : r_q + 16'd1;
        end else begin
          col_q <= c_q + AW'(1);
        end
      end else if (cmd_i.pop) begin
        q0_q <= q1_q; cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign sts_o.need_sqrt = interior && b_flag_q && comp_q;
  assign sts_o.acc_done  = k_q == 4'd8;
  assign sts_o.sqrt_done = sk_q == 5'd18;
  assign sts_o.res_empty = cnt_q == 2'd0;

  assign write_enable_o = q0_q[45];
  assign out_row_o      = q0_q[44:29];
  assign out_column_o   = q0_q[28:17];
  assign out_value_o    = q0_q[16:1];
  assign last_of_run_o  = (cnt_q == 2'd1) ? 1'b1 : q0_q[0];
endmodule
`default_nettype wire

@@ sv/ndr3_ctrl.sv @@
`default_nettype none
module ndr3_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire ndr3_pkg::ndr3_sts_t sts_i,
  output ndr3_pkg::ndr3_cmd_t      cmd_o
);
  import ndr3_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SQ0  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  // results drain before the next item is taken
  assign in_ready_o  = (state_q == S_IDLE) && sts_i.res_empty;
  assign out_valid_o = (state_q == S_IDLE) && !sts_i.res_empty;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.pop = out_valid_o && out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!sts_i.need_sqrt) state_d = S_FIN;
        else if (sts_i.acc_done) state_d = S_SQ0;
        else cmd_o.acc = 1'b1;
      end
      S_SQ0: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (sts_i.sqrt_done) state_d = S_FIN;
        else cmd_o.sqrt_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

@@ sv/neighbour_difference_rms_3x3_unit.sv @@
`default_nettype none
// 3x3 neighbour-difference RMS filter over a raster stream of 16-bit pixels
// with 8-bit mask bytes.
// Input channel: in_valid_i / in_ready_o with pixel_value_i, mask_value_i.
// Output channel: out_valid_o / out_ready_i; each item gives 0, 1 or 2
// results (interior result one row and column behind, then border result),
// last_of_run_o marks the final one.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Writing width or height restarts the raster at row 0, column 0.
// Processing: an item with no root needed skips the arithmetic; otherwise
// 8 multiply-accumulate steps run through one multiplier, then 18 root
// steps. Results are then shown, and the next item is taken once they
// have been taken.
// A stalled receiver holds the results and blocks new input.
// Reset restores width 640, height 480, add off, compute on, position 0;
// line store contents are undefined until the first row is written.
module neighbour_difference_rms_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] pixel_value_i,
  input  wire logic [7:0]  mask_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             write_enable_o,
  output logic [15:0]      out_row_o,
  output logic [11:0]      out_column_o,
  output logic [15:0]      out_value_o,
  output logic             last_of_run_o
);
  import ndr3_pkg::*;

  ndr3_cmd_t cmd;
  ndr3_sts_t sts;

  ndr3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ndr3_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .pixel_value_i, .mask_value_i,
    .write_enable_o, .out_row_o, .out_column_o, .out_value_o, .last_of_run_o
  );
endmodule
`default_nettype wire
